/* src/polygon_circle_collision_core_defines.svh */
// Assertion macros for the polygon/circle collision checker.
`ifndef POLYGON_CIRCLE_COLLISION_CORE_DEFINES_SVH
`define POLYGON_CIRCLE_COLLISION_CORE_DEFINES_SVH

// Condition must hold at every sampled edge outside reset.
`define PCC_ASSERT_NOW(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// Consequent must hold in the same cycle as the antecedent.
`define PCC_ASSERT_IMPLY(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define PCC_ASSERT_THEN(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

/* src/pcc_pkg.sv */
// Shared constants, types and codes of the polygon/circle collision block.
package pcc_pkg;

  // Store geometry
  localparam int MAX_VERTICES = 16;
  localparam int ADDR_W       = $clog2(MAX_VERTICES);
  localparam int CNT_W        = $clog2(MAX_VERTICES + 1);

  // Datapath widths
  localparam int COORD_W = 16;
  localparam int RAD_W   = 15;
  localparam int DIFF_W  = COORD_W + 1;   // difference of two coordinates
  localparam int MUL_W   = DIFF_W + 1;    // signed multiplier operand
  localparam int PROD_W  = 2 * MUL_W;
  localparam int SPLIT   = DIFF_W;        // split point of wide operands
  localparam int WIDE_W  = 2 * DIFF_W;    // magnitude of cross, length, radius squared
  localparam int T_W     = WIDE_W + 2;    // signed dot and cross products
  localparam int ACC_W   = 2 * WIDE_W + 4;
  localparam int STEP_W  = 3;

  typedef logic signed [COORD_W-1:0] coord_t;
  typedef logic signed [DIFF_W-1:0]  diff_t;
  typedef logic signed [MUL_W-1:0]   mul_t;
  typedef logic signed [PROD_W-1:0]  prod_t;
  typedef logic signed [ACC_W-1:0]   acc_t;
  typedef logic signed [T_W-1:0]     sdot_t;
  typedef logic [WIDE_W-1:0]         wide_t;
  typedef logic [SPLIT-1:0]          half_t;
  typedef logic [RAD_W-1:0]          radius_t;
  typedef logic [ADDR_W-1:0]         addr_t;
  typedef logic [CNT_W-1:0]          cnt_t;
  typedef logic [STEP_W-1:0]         step_t;

  // Last micro-step of each operation group
  localparam step_t STEP_PROD_LAST = step_t'(5);
  localparam step_t STEP_D2_LAST   = step_t'(1);
  localparam step_t STEP_BIG_LAST  = step_t'(6);

  typedef enum logic [1:0] {
    CAUSE_MISS   = 2'd0,
    CAUSE_INSIDE = 2'd1,
    CAUSE_EDGE   = 2'd2
  } cause_t;

  // Left shift applied to a product before accumulation
  typedef enum logic [1:0] {
    SH_NONE,
    SH_LO,
    SH_LO1,
    SH_HI
  } shift_t;

  // Marks the last product of a group so the sum can be picked up
  typedef enum logic [2:0] {
    TAG_NONE,
    TAG_R2,
    TAG_CR,
    TAG_LEN,
    TAG_T,
    TAG_D2,
    TAG_BIG
  } tag_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_RSQ,
    S_RD_A,
    S_RD_B,
    S_DIFF,
    S_PROD,
    S_PROD_WAIT,
    S_DECIDE,
    S_D2,
    S_D2_WAIT,
    S_BIG,
    S_BIG_WAIT,
    S_NEXT,
    S_DONE
  } state_t;

  typedef struct packed {
    logic   valid;
    logic   clear;
    logic   neg;
    shift_t shift;
    tag_t   tag;
    mul_t   a;
    mul_t   b;
  } mac_op_t;

  typedef struct packed {
    tag_t tag;
    acc_t acc;
  } mac_res_t;

  typedef struct packed {
    logic    start;
    coord_t  cx;
    coord_t  cy;
    radius_t r;
    cnt_t    n;
  } seq_cmd_t;

  typedef struct packed {
    logic   idle;
    logic   done;
    cause_t cause;
  } seq_stat_t;

endpackage

/* src/pcc_vstore.sv */
// Polygon vertex store: one write port, one registered read port.
module pcc_vstore (
  input  logic           clk,
  input  logic           wr_en,
  input  pcc_pkg::addr_t wr_addr,
  input  pcc_pkg::coord_t wr_x,
  input  pcc_pkg::coord_t wr_y,
  input  pcc_pkg::addr_t rd_addr,
  output pcc_pkg::coord_t rd_x,
  output pcc_pkg::coord_t rd_y
);

  logic [2*pcc_pkg::COORD_W-1:0] mem [pcc_pkg::MAX_VERTICES];
  logic [2*pcc_pkg::COORD_W-1:0] rd_word;

  // Write one vertex per load beat
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= {wr_x, wr_y};
    end
  end

  // Register the read word
  always_ff @(posedge clk) begin
    rd_word <= mem[rd_addr];
  end

  assign rd_x = pcc_pkg::coord_t'(rd_word[2*pcc_pkg::COORD_W-1:pcc_pkg::COORD_W]);
  assign rd_y = pcc_pkg::coord_t'(rd_word[pcc_pkg::COORD_W-1:0]);

endmodule

/* src/pcc_mac.sv */
// Shared multiply-accumulate unit: registered product, then shifted accumulate.
module pcc_mac (
  input  logic              clk,
  input  logic              rst,
  input  pcc_pkg::mac_op_t  op,
  output pcc_pkg::mac_res_t res
);

  logic             p_valid;
  logic             p_clear;
  logic             p_neg;
  pcc_pkg::shift_t  p_shift;
  pcc_pkg::tag_t    p_tag;
  pcc_pkg::prod_t   p_prod;
  pcc_pkg::acc_t    acc;
  pcc_pkg::acc_t    acc_next;
  pcc_pkg::acc_t    ext;
  pcc_pkg::acc_t    addend;
  pcc_pkg::acc_t    base;
  pcc_pkg::tag_t    out_tag;

  // Product stage
  always_ff @(posedge clk) begin
    if (rst) begin
      p_valid <= 1'b0;
    end else begin
      p_valid <= op.valid;
    end
  end

  always_ff @(posedge clk) begin
    p_clear <= op.clear;
    p_neg   <= op.neg;
    p_shift <= op.shift;
    p_tag   <= op.tag;
    p_prod  <= op.a * op.b;
  end

  // Align the product and add or subtract it
  always_comb begin
    ext = pcc_pkg::acc_t'(p_prod);
    unique case (p_shift)
      pcc_pkg::SH_NONE: addend = ext;
      pcc_pkg::SH_LO:   addend = ext <<< pcc_pkg::SPLIT;
      pcc_pkg::SH_LO1:  addend = ext <<< (pcc_pkg::SPLIT + 1);
      pcc_pkg::SH_HI:   addend = ext <<< (2 * pcc_pkg::SPLIT);
      default:          addend = ext;
    endcase
    base     = p_clear ? '0 : acc;
    acc_next = p_neg ? (base - addend) : (base + addend);
  end

  // Accumulate stage, tag follows the product that completes a group
  always_ff @(posedge clk) begin
    if (rst) begin
      out_tag <= pcc_pkg::TAG_NONE;
    end else begin
      out_tag <= p_valid ? p_tag : pcc_pkg::TAG_NONE;
    end
  end

  always_ff @(posedge clk) begin
    if (p_valid) begin
      acc <= acc_next;
    end
  end

  assign res.tag = out_tag;
  assign res.acc = acc;

endmodule

/* src/pcc_seq.sv */
// Query sequencer: walks the stored edges and drives the shared MAC unit.
module pcc_seq (
  input  logic               clk,
  input  logic               rst,
  input  pcc_pkg::seq_cmd_t  cmd,
  input  logic               out_free,
  input  pcc_pkg::coord_t    rd_x,
  input  pcc_pkg::coord_t    rd_y,
  input  pcc_pkg::mac_res_t  mac_res,
  output pcc_pkg::addr_t     rd_addr,
  output pcc_pkg::mac_op_t   mac_op,
  output pcc_pkg::seq_stat_t stat
);

  pcc_pkg::state_t  state;
  pcc_pkg::state_t  state_next;
  pcc_pkg::step_t   step;
  pcc_pkg::addr_t   idx;
  logic             odd_cross;
  logic             near;

  // Query operands
  pcc_pkg::coord_t  cx;
  pcc_pkg::coord_t  cy;
  pcc_pkg::radius_t r;
  pcc_pkg::wide_t   r2;

  // Edge operands
  pcc_pkg::coord_t  ax;
  pcc_pkg::coord_t  ay;
  pcc_pkg::diff_t   dx;
  pcc_pkg::diff_t   dy;
  pcc_pkg::diff_t   wx;
  pcc_pkg::diff_t   wy;
  pcc_pkg::diff_t   ex;
  pcc_pkg::diff_t   ey;
  logic             straddle;
  logic             dy_pos;
  logic             use_end;

  // Products picked up from the MAC
  pcc_pkg::sdot_t   cr;
  pcc_pkg::sdot_t   t;
  pcc_pkg::wide_t   len;
  pcc_pkg::wide_t   c;

  pcc_pkg::cnt_t    idx_inc;
  logic             last_edge;
  pcc_pkg::addr_t   k;
  logic             crosses;
  logic             len_zero;
  logic             t_neg;
  logic             t_gt_len;
  pcc_pkg::sdot_t   cr_mag;
  pcc_pkg::half_t   c_hi;
  pcc_pkg::half_t   c_lo;
  pcc_pkg::half_t   r2_hi;
  pcc_pkg::half_t   r2_lo;
  pcc_pkg::half_t   len_hi;
  pcc_pkg::half_t   len_lo;
  pcc_pkg::diff_t   d2_x;
  pcc_pkg::diff_t   d2_y;

  function automatic pcc_pkg::mac_op_t mk_op(
    input pcc_pkg::mul_t   a,
    input pcc_pkg::mul_t   b,
    input logic            clear,
    input logic            neg,
    input pcc_pkg::shift_t shift,
    input pcc_pkg::tag_t   tag
  );
    pcc_pkg::mac_op_t o;
    o.valid = 1'b1;
    o.clear = clear;
    o.neg   = neg;
    o.shift = shift;
    o.tag   = tag;
    o.a     = a;
    o.b     = b;
    return o;
  endfunction

  // Edge index and its successor around the polygon
  always_comb begin
    idx_inc   = pcc_pkg::cnt_t'(idx) + pcc_pkg::cnt_t'(1);
    last_edge = (idx_inc == cmd.n);
    k         = last_edge ? '0 : idx_inc[pcc_pkg::ADDR_W-1:0];
    rd_addr   = (state == pcc_pkg::S_RD_B) ? k : idx;
  end

  // Edge decisions
  always_comb begin
    crosses  = dy_pos ? cr[pcc_pkg::T_W-1] : (!cr[pcc_pkg::T_W-1] && (cr != '0));
    len_zero = (len == '0);
    t_neg    = t[pcc_pkg::T_W-1];
    t_gt_len = (t > pcc_pkg::sdot_t'(len));
    cr_mag   = cr[pcc_pkg::T_W-1] ? -cr : cr;
    c_hi     = c[pcc_pkg::WIDE_W-1:pcc_pkg::SPLIT];
    c_lo     = c[pcc_pkg::SPLIT-1:0];
    r2_hi    = r2[pcc_pkg::WIDE_W-1:pcc_pkg::SPLIT];
    r2_lo    = r2[pcc_pkg::SPLIT-1:0];
    len_hi   = len[pcc_pkg::WIDE_W-1:pcc_pkg::SPLIT];
    len_lo   = len[pcc_pkg::SPLIT-1:0];
    d2_x     = use_end ? ex : wx;
    d2_y     = use_end ? ey : wy;
  end

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      pcc_pkg::S_IDLE: begin
        if (cmd.start) begin
          state_next = (cmd.n == '0) ? pcc_pkg::S_DONE : pcc_pkg::S_RSQ;
        end
      end
      pcc_pkg::S_RSQ:  state_next = pcc_pkg::S_RD_A;
      pcc_pkg::S_RD_A: state_next = pcc_pkg::S_RD_B;
      pcc_pkg::S_RD_B: state_next = pcc_pkg::S_DIFF;
      pcc_pkg::S_DIFF: state_next = pcc_pkg::S_PROD;
      pcc_pkg::S_PROD: begin
        if (step == pcc_pkg::STEP_PROD_LAST) state_next = pcc_pkg::S_PROD_WAIT;
      end
      pcc_pkg::S_PROD_WAIT: begin
        if (mac_res.tag == pcc_pkg::TAG_T) state_next = pcc_pkg::S_DECIDE;
      end
      pcc_pkg::S_DECIDE: begin
        if (near || len_zero) begin
          state_next = pcc_pkg::S_NEXT;
        end else if (t_neg || t_gt_len) begin
          state_next = pcc_pkg::S_D2;
        end else begin
          state_next = pcc_pkg::S_BIG;
        end
      end
      pcc_pkg::S_D2: begin
        if (step == pcc_pkg::STEP_D2_LAST) state_next = pcc_pkg::S_D2_WAIT;
      end
      pcc_pkg::S_D2_WAIT: begin
        if (mac_res.tag == pcc_pkg::TAG_D2) state_next = pcc_pkg::S_NEXT;
      end
      pcc_pkg::S_BIG: begin
        if (step == pcc_pkg::STEP_BIG_LAST) state_next = pcc_pkg::S_BIG_WAIT;
      end
      pcc_pkg::S_BIG_WAIT: begin
        if (mac_res.tag == pcc_pkg::TAG_BIG) state_next = pcc_pkg::S_NEXT;
      end
      pcc_pkg::S_NEXT: begin
        state_next = last_edge ? pcc_pkg::S_DONE : pcc_pkg::S_RD_A;
      end
      pcc_pkg::S_DONE: begin
        if (out_free) state_next = pcc_pkg::S_IDLE;
      end
      default: state_next = pcc_pkg::S_IDLE;
    endcase
  end

  // MAC issue and status
  always_comb begin
    mac_op       = '0;
    mac_op.shift = pcc_pkg::SH_NONE;
    mac_op.tag   = pcc_pkg::TAG_NONE;
    unique case (state)
      pcc_pkg::S_RSQ: begin
        mac_op = mk_op(pcc_pkg::mul_t'(r), pcc_pkg::mul_t'(r), 1'b1, 1'b0,
                       pcc_pkg::SH_NONE, pcc_pkg::TAG_R2);
      end
      pcc_pkg::S_PROD: begin
        unique case (step)
          3'd0: mac_op = mk_op(pcc_pkg::mul_t'(wx), pcc_pkg::mul_t'(dy), 1'b1, 1'b0,
                               pcc_pkg::SH_NONE, pcc_pkg::TAG_NONE);
          3'd1: mac_op = mk_op(pcc_pkg::mul_t'(wy), pcc_pkg::mul_t'(dx), 1'b0, 1'b1,
                               pcc_pkg::SH_NONE, pcc_pkg::TAG_CR);
          3'd2: mac_op = mk_op(pcc_pkg::mul_t'(dx), pcc_pkg::mul_t'(dx), 1'b1, 1'b0,
                               pcc_pkg::SH_NONE, pcc_pkg::TAG_NONE);
          3'd3: mac_op = mk_op(pcc_pkg::mul_t'(dy), pcc_pkg::mul_t'(dy), 1'b0, 1'b0,
                               pcc_pkg::SH_NONE, pcc_pkg::TAG_LEN);
          3'd4: mac_op = mk_op(pcc_pkg::mul_t'(wx), pcc_pkg::mul_t'(dx), 1'b1, 1'b0,
                               pcc_pkg::SH_NONE, pcc_pkg::TAG_NONE);
          3'd5: mac_op = mk_op(pcc_pkg::mul_t'(wy), pcc_pkg::mul_t'(dy), 1'b0, 1'b0,
                               pcc_pkg::SH_NONE, pcc_pkg::TAG_T);
          default: ;
        endcase
      end
      pcc_pkg::S_D2: begin
        unique case (step)
          3'd0: mac_op = mk_op(pcc_pkg::mul_t'(d2_x), pcc_pkg::mul_t'(d2_x), 1'b1, 1'b0,
                               pcc_pkg::SH_NONE, pcc_pkg::TAG_NONE);
          3'd1: mac_op = mk_op(pcc_pkg::mul_t'(d2_y), pcc_pkg::mul_t'(d2_y), 1'b0, 1'b0,
                               pcc_pkg::SH_NONE, pcc_pkg::TAG_D2);
          default: ;
        endcase
      end
      pcc_pkg::S_BIG: begin
        // cross squared minus radius squared times edge length squared
        unique case (step)
          3'd0: mac_op = mk_op(pcc_pkg::mul_t'(c_hi), pcc_pkg::mul_t'(c_hi), 1'b1, 1'b0,
                               pcc_pkg::SH_HI, pcc_pkg::TAG_NONE);
          3'd1: mac_op = mk_op(pcc_pkg::mul_t'(c_hi), pcc_pkg::mul_t'(c_lo), 1'b0, 1'b0,
                               pcc_pkg::SH_LO1, pcc_pkg::TAG_NONE);
          3'd2: mac_op = mk_op(pcc_pkg::mul_t'(c_lo), pcc_pkg::mul_t'(c_lo), 1'b0, 1'b0,
                               pcc_pkg::SH_NONE, pcc_pkg::TAG_NONE);
          3'd3: mac_op = mk_op(pcc_pkg::mul_t'(r2_hi), pcc_pkg::mul_t'(len_hi), 1'b0, 1'b1,
                               pcc_pkg::SH_HI, pcc_pkg::TAG_NONE);
          3'd4: mac_op = mk_op(pcc_pkg::mul_t'(r2_hi), pcc_pkg::mul_t'(len_lo), 1'b0, 1'b1,
                               pcc_pkg::SH_LO, pcc_pkg::TAG_NONE);
          3'd5: mac_op = mk_op(pcc_pkg::mul_t'(r2_lo), pcc_pkg::mul_t'(len_hi), 1'b0, 1'b1,
                               pcc_pkg::SH_LO, pcc_pkg::TAG_NONE);
          3'd6: mac_op = mk_op(pcc_pkg::mul_t'(r2_lo), pcc_pkg::mul_t'(len_lo), 1'b0, 1'b1,
                               pcc_pkg::SH_NONE, pcc_pkg::TAG_BIG);
          default: ;
        endcase
      end
      default: ;
    endcase

    stat.idle  = (state == pcc_pkg::S_IDLE);
    stat.done  = (state == pcc_pkg::S_DONE);
    stat.cause = odd_cross ? pcc_pkg::CAUSE_INSIDE :
                 (near ? pcc_pkg::CAUSE_EDGE : pcc_pkg::CAUSE_MISS);
  end

  // Sequencer control
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= pcc_pkg::S_IDLE;
      step      <= '0;
      idx       <= '0;
      odd_cross <= 1'b0;
      near      <= 1'b0;
    end else begin
      state <= state_next;
      step  <= (state_next != state) ? '0 : step + pcc_pkg::step_t'(1);
      priority if (state == pcc_pkg::S_IDLE && cmd.start) begin
        idx       <= '0;
        odd_cross <= 1'b0;
        near      <= 1'b0;
      end else if (state == pcc_pkg::S_DECIDE) begin
        if (straddle && crosses) odd_cross <= !odd_cross;
      end else if (state == pcc_pkg::S_D2_WAIT && mac_res.tag == pcc_pkg::TAG_D2) begin
        if (mac_res.acc < pcc_pkg::acc_t'(r2)) near <= 1'b1;
      end else if (state == pcc_pkg::S_BIG_WAIT && mac_res.tag == pcc_pkg::TAG_BIG) begin
        if (mac_res.acc[pcc_pkg::ACC_W-1]) near <= 1'b1;
      end else if (state == pcc_pkg::S_NEXT && !last_edge) begin
        idx <= idx_inc[pcc_pkg::ADDR_W-1:0];
      end
    end
  end

  // Query and edge operands
  always_ff @(posedge clk) begin
    if (state == pcc_pkg::S_IDLE && cmd.start) begin
      cx <= cmd.cx;
      cy <= cmd.cy;
      r  <= cmd.r;
    end
    if (state == pcc_pkg::S_RD_B) begin
      ax <= rd_x;
      ay <= rd_y;
    end
    if (state == pcc_pkg::S_DIFF) begin
      dx       <= pcc_pkg::diff_t'(rd_x) - pcc_pkg::diff_t'(ax);
      dy       <= pcc_pkg::diff_t'(rd_y) - pcc_pkg::diff_t'(ay);
      wx       <= pcc_pkg::diff_t'(cx) - pcc_pkg::diff_t'(ax);
      wy       <= pcc_pkg::diff_t'(cy) - pcc_pkg::diff_t'(ay);
      ex       <= pcc_pkg::diff_t'(cx) - pcc_pkg::diff_t'(rd_x);
      ey       <= pcc_pkg::diff_t'(cy) - pcc_pkg::diff_t'(rd_y);
      straddle <= (ay > cy) != (rd_y > cy);
      dy_pos   <= rd_y > ay;
    end
    if (state == pcc_pkg::S_DECIDE) begin
      c       <= cr_mag[pcc_pkg::WIDE_W-1:0];
      use_end <= !t_neg;
    end
  end

  // Pick up finished sums
  always_ff @(posedge clk) begin
    unique case (mac_res.tag)
      pcc_pkg::TAG_R2:  r2  <= mac_res.acc[pcc_pkg::WIDE_W-1:0];
      pcc_pkg::TAG_CR:  cr  <= mac_res.acc[pcc_pkg::T_W-1:0];
      pcc_pkg::TAG_LEN: len <= mac_res.acc[pcc_pkg::WIDE_W-1:0];
      pcc_pkg::TAG_T:   t   <= mac_res.acc[pcc_pkg::T_W-1:0];
      default: ;
    endcase
  end

endmodule

/* src/polygon_circle_collision_core.sv */
// Polygon versus circle collision core: load path, vertex store, result register.
//
// One request channel (req_valid/req_stall) carries both kinds of beat. With mode
// low a beat loads one polygon vertex; vertex_last closes the polygon so the next
// load starts a fresh one. Vertices past the store depth are dropped and flagged.
// With mode high a beat runs a circle query against the vertices stored so far.
// A load produces no result. A query produces one result beat
// on rsp_valid/rsp_stall carrying hit, cause and overflowed.
// A query runs on the shared multiply-accumulate unit, one product per cycle:
// the radius is squared first, then each stored edge is handled in turn (read
// two vertices, cross/length/dot products, then nothing more, the endpoint
// distance or the wide projected-distance compare), and the sequencer ends in
// its done state. With an empty polygon it goes straight to its done state.
// req_stall stays high while a query runs. A finished result sits in the output
// register; if that is still stalled, the sequencer holds in its done state.
// Reset empties the polygon and clears the dropped flag and any pending result.
module polygon_circle_collision_core (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   req_valid,
  output logic                   req_stall,
  input  logic                   mode,
  input  logic signed [15:0]     vertex_x,
  input  logic signed [15:0]     vertex_y,
  input  logic                   vertex_last,
  input  logic signed [15:0]     center_x,
  input  logic signed [15:0]     center_y,
  input  logic [14:0]            radius,
  output logic                   rsp_valid,
  input  logic                   rsp_stall,
  output logic                   hit,
  output logic [1:0]             cause,
  output logic                   overflowed
);

  pcc_pkg::cnt_t      count;
  logic               start_new;
  logic               dropped;
  pcc_pkg::cnt_t      base;
  logic               room;
  logic               load_acc;
  logic               wr_en;
  logic               out_free;
  pcc_pkg::seq_cmd_t  cmd;
  pcc_pkg::seq_stat_t stat;
  pcc_pkg::mac_op_t   mac_op;
  pcc_pkg::mac_res_t  mac_res;
  pcc_pkg::addr_t     rd_addr;
  pcc_pkg::coord_t    rd_x;
  pcc_pkg::coord_t    rd_y;

  // Accept a beat only while the sequencer is idle
  assign req_stall = !stat.idle;
  assign load_acc  = req_valid && !req_stall && !mode;
  assign out_free  = !rsp_valid || !rsp_stall;

  assign cmd.start = req_valid && !req_stall && mode;
  assign cmd.cx    = center_x;
  assign cmd.cy    = center_y;
  assign cmd.r     = radius;
  assign cmd.n     = count;

  // Load path: restart on a new polygon, drop beyond the store depth
  always_comb begin
    base  = start_new ? '0 : count;
    room  = base < pcc_pkg::cnt_t'(pcc_pkg::MAX_VERTICES);
    wr_en = load_acc && room;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      start_new <= 1'b1;
      dropped   <= 1'b0;
    end else if (load_acc) begin
      count     <= room ? base + pcc_pkg::cnt_t'(1) : base;
      dropped   <= (dropped && !start_new) || !room;
      start_new <= vertex_last;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (stat.done && out_free) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (stat.done && out_free) begin
      hit        <= (stat.cause != pcc_pkg::CAUSE_MISS);
      cause      <= stat.cause;
      overflowed <= dropped;
    end
  end

  pcc_vstore u_vstore (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (base[pcc_pkg::ADDR_W-1:0]),
    .wr_x    (vertex_x),
    .wr_y    (vertex_y),
    .rd_addr (rd_addr),
    .rd_x    (rd_x),
    .rd_y    (rd_y)
  );

  pcc_mac u_mac (
    .clk (clk),
    .rst (rst),
    .op  (mac_op),
    .res (mac_res)
  );

  pcc_seq u_seq (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .out_free (out_free),
    .rd_x     (rd_x),
    .rd_y     (rd_y),
    .mac_res  (mac_res),
    .rd_addr  (rd_addr),
    .mac_op   (mac_op),
    .stat     (stat)
  );

endmodule

/* src/pcc_checker.sv */
// Port-level checker for the polygon/circle collision core, with its bind.
`include "polygon_circle_collision_core_defines.svh"

module pcc_checker (
  input logic       clk,
  input logic       rst,
  input logic       req_valid,
  input logic       req_stall,
  input logic       mode,
  input logic       rsp_valid,
  input logic       rsp_stall,
  input logic       hit,
  input logic [1:0] cause,
  input logic       overflowed
);

  // A query beat blocks the request side while it runs
  `PCC_ASSERT_THEN(a_query_blocks, req_valid && !req_stall && mode, req_stall, "query did not block requests")

  // A load beat leaves the block ready for the next beat
  `PCC_ASSERT_THEN(a_load_ready, req_valid && !req_stall && !mode, !req_stall, "load beat stalled the channel")

  // Hit agrees with the reported cause
  `PCC_ASSERT_IMPLY(a_hit_cause, rsp_valid, hit == (cause != pcc_pkg::CAUSE_MISS), "hit and cause disagree")

  // A stalled result beat holds
  `PCC_ASSERT_THEN(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid && $stable(cause) && $stable(hit) && $stable(overflowed), "stalled result changed")

endmodule

bind polygon_circle_collision_core pcc_checker u_pcc_checker (.*);

/* tb/polygon_circle_collision_core_tb.sv */
// Self-checking testbench for the polygon versus circle collision core.
module polygon_circle_collision_core_tb;

  timeunit 1ns;
  timeprecision 1ps;

  localparam logic MODE_LOAD   = 1'b0;
  localparam logic MODE_QUERY  = 1'b1;
  localparam int   QUIET_LIMIT = 8000;
  localparam int   CALM_FIRST  = 170;
  localparam int   CALM_LAST   = 270;
  localparam int   TOTAL_BEATS = 380;

  typedef struct packed {
    logic            hit;
    pcc_pkg::cause_t cause;
    logic            overflowed;
  } verdict_t;

  typedef struct {
    logic             m;
    pcc_pkg::coord_t  vx;
    pcc_pkg::coord_t  vy;
    logic             closing;
    pcc_pkg::coord_t  cx;
    pcc_pkg::coord_t  cy;
    pcc_pkg::radius_t r;
  } beat_t;

  // Polygon store mirror plus the queue of verdicts still owed by the block
  class collision_scoreboard;
    pcc_pkg::coord_t corner_x [pcc_pkg::MAX_VERTICES];
    pcc_pkg::coord_t corner_y [pcc_pkg::MAX_VERTICES];
    int              corner_count;
    bit              new_shape;
    bit              dropped;
    verdict_t        awaited[$];
    int              faults;

    function new();
      corner_count = 0;
      new_shape    = 1'b1;
      dropped      = 1'b0;
      faults       = 0;
    endfunction

    // Even-odd ray crossing, division replaced by cross-multiplication
    function bit centre_inside(longint cx, longint cy);
      bit     odd;
      int     j;
      longint ax, ay, bx, by, den, num, lhs;
      odd = 1'b0;
      j   = corner_count - 1;
      for (int i = 0; i < corner_count; i++) begin
        ax = corner_x[i];
        ay = corner_y[i];
        bx = corner_x[j];
        by = corner_y[j];
        if ((ay > cy) != (by > cy)) begin
          den = by - ay;
          num = (bx - ax) * (cy - ay);
          lhs = (cx - ax) * den;
          if (den > 0 ? lhs < num : lhs > num)
            odd = !odd;
        end
        j = i;
      end
      return odd;
    endfunction

    // Nearest point of each non-degenerate edge strictly inside the radius
    function bit edge_near(longint cx, longint cy, longint r2);
      int           k;
      longint       ax, ay, dx, dy, wx, wy, len, t, ex, ey, c;
      logic [127:0] c_w, len_w, r2_w;
      for (int i = 0; i < corner_count; i++) begin
        k   = (i + 1 < corner_count) ? i + 1 : 0;
        ax  = corner_x[i];
        ay  = corner_y[i];
        dx  = longint'(corner_x[k]) - ax;
        dy  = longint'(corner_y[k]) - ay;
        wx  = cx - ax;
        wy  = cy - ay;
        len = dx * dx + dy * dy;
        if (len == 0)
          continue;
        t = wx * dx + wy * dy;
        if (t < 0) begin
          if (wx * wx + wy * wy < r2)
            return 1'b1;
        end else if (t > len) begin
          ex = cx - longint'(corner_x[k]);
          ey = cy - longint'(corner_y[k]);
          if (ex * ex + ey * ey < r2)
            return 1'b1;
        end else begin
          c = wx * dy - wy * dx;
          if (c < 0)
            c = -c;
          c_w   = c;
          len_w = len;
          r2_w  = r2;
          if (c_w * c_w < r2_w * len_w)
            return 1'b1;
        end
      end
      return 1'b0;
    endfunction

    // Update the polygon on a load, owe a verdict on a query
    function void note_beat(logic m, pcc_pkg::coord_t vx, pcc_pkg::coord_t vy,
                            logic closing, pcc_pkg::coord_t cx, pcc_pkg::coord_t cy,
                            pcc_pkg::radius_t r);
      verdict_t v;
      longint   r2;
      if (m == MODE_LOAD) begin
        if (new_shape) begin
          corner_count = 0;
          dropped      = 1'b0;
          new_shape    = 1'b0;
        end
        if (corner_count < pcc_pkg::MAX_VERTICES) begin
          corner_x[corner_count] = vx;
          corner_y[corner_count] = vy;
          corner_count++;
        end else begin
          dropped = 1'b1;
        end
        if (closing)
          new_shape = 1'b1;
      end else begin
        r2      = longint'(r) * longint'(r);
        v.cause = pcc_pkg::CAUSE_MISS;
        if (corner_count > 0) begin
          if (centre_inside(cx, cy))
            v.cause = pcc_pkg::CAUSE_INSIDE;
          else if (edge_near(cx, cy, r2))
            v.cause = pcc_pkg::CAUSE_EDGE;
        end
        v.hit        = (v.cause != pcc_pkg::CAUSE_MISS);
        v.overflowed = dropped;
        awaited.insert(awaited.size(), v);
      end
    endfunction

    // Compare one result beat against the oldest owed verdict
    function void check_verdict(logic h, logic [1:0] c, logic o);
      verdict_t want;
      if (awaited.size() == 0) begin
        if (faults < 10)
          $display("unexpected result beat: hit=%0d cause=%0d overflowed=%0d", h, c, o);
        faults++;
        return;
      end
      want = awaited.pop_front();
      if (h !== want.hit || c !== want.cause || o !== want.overflowed) begin
        if (faults < 10)
          $display({"mismatch: expected hit=%0d cause=%0d overflowed=%0d, ",
                    "got hit=%0d cause=%0d overflowed=%0d"},
                   want.hit, want.cause, want.overflowed, h, c, o);
        faults++;
      end
    endfunction
  endclass

  logic                clk = 1'b0;
  logic                rst;
  logic                req_valid;
  logic                req_stall;
  logic                mode;
  logic signed [15:0]  vertex_x;
  logic signed [15:0]  vertex_y;
  logic                vertex_last;
  logic signed [15:0]  center_x;
  logic signed [15:0]  center_y;
  logic [14:0]         radius;
  logic                rsp_valid;
  logic                rsp_stall;
  logic                hit;
  logic [1:0]          cause;
  logic                overflowed;

  collision_scoreboard sb;
  bit                  calm = 1'b0;
  int                  beats_sent = 0;
  int                  quiet_cycles = 0;

  polygon_circle_collision_core u_dut (
    .clk         (clk),
    .rst         (rst),
    .req_valid   (req_valid),
    .req_stall   (req_stall),
    .mode        (mode),
    .vertex_x    (vertex_x),
    .vertex_y    (vertex_y),
    .vertex_last (vertex_last),
    .center_x    (center_x),
    .center_y    (center_y),
    .radius      (radius),
    .rsp_valid   (rsp_valid),
    .rsp_stall   (rsp_stall),
    .hit         (hit),
    .cause       (cause),
    .overflowed  (overflowed)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Stall the result channel at random, never inside the calm stretch
  always @(posedge clk) begin
    rsp_stall <= !calm && ($urandom_range(0, 99) < 36);
  end

  // Watch both channels at the edge the block samples them
  always @(posedge clk) begin
    if (!rst) begin
      if (req_valid && !req_stall)
        sb.note_beat(mode, vertex_x, vertex_y, vertex_last, center_x, center_y, radius);
      if (rsp_valid && !rsp_stall)
        sb.check_verdict(hit, cause, overflowed);
    end
  end

  // End the run when neither channel moves for too long
  always @(posedge clk) begin
    if (rst || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("FAIL");
        $finish;
      end
    end
  end

  function automatic pcc_pkg::coord_t any_coord();
    return pcc_pkg::coord_t'($urandom_range(0, 65535));
  endfunction

  // Pick a coordinate within spread of base, clamped to the field range
  function automatic pcc_pkg::coord_t near(longint base, longint spread);
    longint v;
    v = base + longint'($urandom_range(0, 32'(2 * spread))) - spread;
    if (v > 32767)
      v = 32767;
    if (v < -32768)
      v = -32768;
    return pcc_pkg::coord_t'(v);
  endfunction

  function automatic beat_t vertex_beat(longint x, longint y, bit closing);
    beat_t b;
    b.m       = MODE_LOAD;
    b.vx      = pcc_pkg::coord_t'(x);
    b.vy      = pcc_pkg::coord_t'(y);
    b.closing = closing;
    b.cx      = any_coord();
    b.cy      = any_coord();
    b.r       = pcc_pkg::radius_t'($urandom_range(0, 32767));
    return b;
  endfunction

  function automatic beat_t circle_beat(longint x, longint y, longint r);
    beat_t b;
    b.m       = MODE_QUERY;
    b.vx      = any_coord();
    b.vy      = any_coord();
    b.closing = 1'($urandom_range(0, 1));
    b.cx      = pcc_pkg::coord_t'(x);
    b.cy      = pcc_pkg::coord_t'(y);
    b.r       = pcc_pkg::radius_t'(r);
    return b;
  endfunction

  // Offer one beat after a random gap, hold it until accepted
  task automatic send(input beat_t b);
    calm = (beats_sent >= CALM_FIRST && beats_sent < CALM_LAST);
    while (!calm && $urandom_range(0, 99) < 36) begin
      req_valid <= 1'b0;
      @(posedge clk);
    end
    req_valid   <= 1'b1;
    mode        <= b.m;
    vertex_x    <= b.vx;
    vertex_y    <= b.vy;
    vertex_last <= b.closing;
    center_x    <= b.cx;
    center_y    <= b.cy;
    radius      <= b.r;
    @(posedge clk);
    while (req_stall)
      @(posedge clk);
    beats_sent++;
  endtask

  // Let the last accepted beat reach the scoreboard, then wait out the owed verdicts
  task automatic drain();
    @(posedge clk);
    while (sb.awaited.size() != 0)
      @(posedge clk);
  endtask

  // One random polygon with a few queries around it
  task automatic polygon_round();
    int     pick, n, mid_query;
    longint spread, base_x, base_y, r;
    pick = $urandom_range(0, 99);
    if (pick < 10)
      n = $urandom_range(1, 2);
    else if (pick < 20)
      n = $urandom_range(17, 20);
    else if (pick < 25)
      n = pcc_pkg::MAX_VERTICES;
    else
      n = $urandom_range(3, 8);
    spread    = longint'(1) << $urandom_range(2, 15);
    base_x    = longint'($urandom_range(0, 65535)) - 32768;
    base_y    = longint'($urandom_range(0, 65535)) - 32768;
    mid_query = (n > 1 && $urandom_range(0, 9) == 0) ? $urandom_range(1, n - 1) : 0;
    for (int v = 0; v < n; v++) begin
      if (mid_query != 0 && v == mid_query)
        send(circle_beat(near(base_x, spread), near(base_y, spread),
                         $urandom_range(0, 32767)));
      send(vertex_beat(near(base_x, spread), near(base_y, spread), v == n - 1));
    end
    repeat ($urandom_range(1, 4)) begin
      if ($urandom_range(0, 9) < 2)
        r = $urandom_range(0, 32767);
      else
        r = (spread > 32767) ? $urandom_range(0, 32767) : $urandom_range(0, 32'(spread));
      send(circle_beat(near(base_x, 2 * spread), near(base_y, 2 * spread), r));
    end
  endtask

  // Broken or arbitrary beat with every field random
  task automatic noise_beat();
    beat_t b;
    b.m       = 1'($urandom_range(0, 1));
    b.vx      = any_coord();
    b.vy      = any_coord();
    b.closing = 1'($urandom_range(0, 1));
    b.cx      = any_coord();
    b.cy      = any_coord();
    b.r       = pcc_pkg::radius_t'($urandom_range(0, 32767));
    send(b);
  endtask

  initial begin
    sb = new();
    rst         <= 1'b1;
    req_valid   <= 1'b0;
    mode        <= MODE_LOAD;
    vertex_x    <= '0;
    vertex_y    <= '0;
    vertex_last <= 1'b0;
    center_x    <= '0;
    center_y    <= '0;
    radius      <= '0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // Empty polygon, then a single vertex
    send(circle_beat(0, 0, 100));
    send(vertex_beat(-32768, -32768, 1'b0));
    send(circle_beat(-32768, -32768, 32767));
    // Two vertices: a segment, tested just inside and exactly at the radius
    send(vertex_beat(32767, -32768, 1'b0));
    send(circle_beat(0, -32760, 9));
    send(circle_beat(0, -32760, 8));
    // Close the full-range square; inside with zero and maximum radius
    send(vertex_beat(32767, 32767, 1'b0));
    send(vertex_beat(-32768, 32767, 1'b1));
    send(circle_beat(0, 0, 0));
    send(circle_beat(0, 0, 32767));
    send(circle_beat(32767, 32767, 32767));
    send(circle_beat(-32768, 0, 1));
    // Triangle with a repeated corner, so one edge has zero length
    send(vertex_beat(5, 5, 1'b0));
    send(vertex_beat(5, 5, 1'b0));
    send(vertex_beat(100, 5, 1'b0));
    send(vertex_beat(5, 100, 1'b1));
    send(circle_beat(40, 40, 0));
    send(circle_beat(200, 200, 10));
    send(circle_beat(50, 0, 6));
    send(circle_beat(50, 0, 5));

    // Hold off until every owed verdict is back
    req_valid <= 1'b0;
    drain();

    while (beats_sent < TOTAL_BEATS) begin
      if ($urandom_range(0, 99) < 85)
        polygon_round();
      else
        noise_beat();
    end
    req_valid <= 1'b0;

    drain();
    repeat (40) @(posedge clk);
    if (sb.faults == 0 && sb.awaited.size() == 0)
      $display("PASS");
    else
      $display("FAIL");
    $finish;
  end

endmodule
